// ----- design/utf16_to_utf8_transcoder_core_defines.svh -----
// Assertion helpers shared by the transcoder modules.
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define UTT_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define UTT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/utt_pkg.sv -----
package utt_pkg;

  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } unit_item_t;

  typedef struct packed {
    logic [31:0] utf8_bytes;
    logic [2:0]  byte_count;
    logic        run_last;
  } char_item_t;

  // What follows the optional lone held surrogate in a command.
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_UNIT,
    TAIL_PAIR
  } tail_t;

  typedef struct packed {
    logic        with_held;
    logic [9:0]  held_high;
    logic [15:0] unit;
    tail_t       tail;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes = {25'b0, cp[6:0]};
      e.count = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes = {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      e.count = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes = {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      e.count = 3'd3;
    end else begin
      e.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                 5'b11110, cp[20:18]};
      e.count = 3'd4;
    end
    return e;
  endfunction

endpackage

// ----- design/utt_front.sv -----
module utt_front
  import utt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       unit_valid,
  output logic       unit_stall,
  input  unit_item_t unit_item,
  input  q_status_t  q_status,
  output logic       push,
  output cmd_t       push_cmd
);

  logic       held_valid;
  logic [9:0] held_high;
  logic       is_hi;
  logic       is_lo;
  logic       hold_new;
  logic       accept;

  assign unit_stall = q_status.full;
  assign accept     = unit_valid && !q_status.full;

  always_comb begin
    is_hi    = unit_item.code_unit inside {[HI_FIRST:HI_LAST]};
    is_lo    = unit_item.code_unit inside {[LO_FIRST:LO_LAST]};
    hold_new = is_hi && !unit_item.final_unit;

    push_cmd.with_held = held_valid && !is_lo;
    push_cmd.held_high = held_high;
    push_cmd.unit      = unit_item.code_unit;
    if (held_valid && is_lo) begin
      push_cmd.tail = TAIL_PAIR;
    end else if (hold_new) begin
      push_cmd.tail = TAIL_NONE;
    end else begin
      push_cmd.tail = TAIL_UNIT;
    end

    // A fresh non-final high surrogate with nothing held yields no command.
    push = accept && (held_valid || !hold_new);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (accept) begin
      held_valid <= hold_new;
      held_high  <= hold_new ? unit_item.code_unit[9:0] : 10'd0;
    end
  end

endmodule

// ----- design/utt_queue.sv -----
`include "utf16_to_utf8_transcoder_core_defines.svh"

module utt_queue
  import utt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head               = slots[rd_ptr];
  assign q_status.not_empty = count != '0;
  assign q_status.full      = count == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UTT_ASSERT_NOW(a_no_overflow, clk, rst, push && !pop, !q_status.full, "queue overflow")
  `UTT_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

// ----- design/utt_back.sv -----
`include "utf16_to_utf8_transcoder_core_defines.svh"

module utt_back
  import utt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       char_valid,
  input  logic       char_stall,
  output char_item_t char_item
);

  logic       phase;
  logic       load;
  logic       emit;
  logic       two;
  logic       use_held;
  logic [20:0] cp;
  enc_t       enc;
  char_item_t char_next;

  always_comb begin
    load     = !char_valid || !char_stall;
    emit     = load && q_status.not_empty;
    two      = head.with_held && (head.tail != TAIL_NONE);
    pop      = emit && (phase || !two);
    use_held = head.with_held && !phase;

    if (use_held) begin
      cp = {5'b0, HI_FIRST[15:10], head.held_high};
    end else if (head.tail == TAIL_PAIR) begin
      cp = SUPP_BASE + {1'b0, head.held_high, head.unit[9:0]};
    end else begin
      cp = {5'b0, head.unit};
    end
    enc = utf8_encode(cp);

    char_next.utf8_bytes = enc.bytes;
    char_next.byte_count = enc.count;
    char_next.run_last   = !use_held || (head.tail == TAIL_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 1'b0;
      char_valid <= 1'b0;
    end else if (load) begin
      char_valid <= q_status.not_empty;
      if (emit) begin
        phase <= two && !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_item <= char_next;
    end
  end

  `UTT_ASSERT_NOW(a_phase_cmd, clk, rst, phase, q_status.not_empty && two, "second result lost")
  `UTT_ASSERT_NOW(a_count_range, clk, rst, char_valid, char_item.byte_count != 3'd0 && char_item.byte_count <= 3'd4, "bad byte count")

endmodule

// ----- design/utf16_to_utf8_transcoder_core.sv -----
// UTF-16 to UTF-8 transcoder.
// Unit channel (unit_valid / unit_stall / unit_item): one 16-bit code unit per
// item plus final_unit marking the last unit of a string. An item is taken at
// a rising edge with unit_valid high and unit_stall low.
// Char channel (char_valid / char_stall / char_item): one UTF-8 character per
// item, first byte in bits 7:0, byte_count valid bytes, run_last on the last
// character caused by a unit.
// A non-final high surrogate is held and produces nothing until the next unit.
// A unit may produce zero, one or two characters.
// A unit's command is written into the command queue, and its character is then encoded into the output register.
// Throughput: one unit per cycle while unit_stall is low; a unit that
// produces two characters holds the encoder for both of them, and the command
// queue (QUEUE_DEPTH entries) soaks this up until it fills, when unit_stall rises.
// While char_stall is high the output register holds its character, the
// queue fills, and unit_stall then holds off new units.
// Reset (synchronous, rst high) clears the held surrogate, empties the queue
// and drops any pending character; there is no clearing pass.
module utf16_to_utf8_transcoder_core
  import utt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       unit_valid,
  output logic       unit_stall,
  input  unit_item_t unit_item,
  output logic       char_valid,
  input  logic       char_stall,
  output char_item_t char_item
);

  // Front to queue: classified commands.
  logic      push;
  cmd_t      push_cmd;
  // Queue to back: head command and fill status.
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  // Front: classify units and track the held high surrogate.
  utt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Short command queue decoupling the two halves.
  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back: encode one character per cycle into the output register, unless char_stall holds it.
  utt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

endmodule

// ----- tb/utf16_to_utf8_transcoder_core_tb.sv -----
module utf16_to_utf8_transcoder_core_tb;
  import utt_pkg::*;

  // Long receiver hold-off: starts when this many characters have been
  // checked, and lasts long enough to fill the command queue.
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 80;
  // Ask the sender to wait for a drained block before this item.
  localparam int DRAIN_AT         = 450;
  localparam int UNIT_TOTAL       = 850;
  // Cycles with no item moving on either channel before giving up.
  localparam int IDLE_LIMIT       = 2000;
  // Settle time after the last expected character.
  localparam int TAIL_CYCLES      = 16;

  typedef struct {
    unit_item_t  item;
    int unsigned gap;          // idle cycles before this item is offered
    bit          drain_first;  // hold until every expected char has come
  } unit_plan_t;

  logic       clk;
  logic       rst        = 1'b1;
  logic       unit_valid = 1'b0;
  logic       unit_stall;
  unit_item_t unit_item  = '0;
  logic       char_valid;
  logic       char_stall = 1'b0;
  char_item_t char_item;

  unit_plan_t  pending_units[$];
  char_item_t  expected_chars[$];

  // Predictor state: the high surrogate waiting for its partner.
  bit          hi_held;
  logic [9:0]  hi_offset;

  int unsigned units_sent;
  int unsigned chars_checked;
  int unsigned char_errors;
  int unsigned pairs_made;
  int unsigned lone_surrogates;
  int unsigned stall_cycles;
  int unsigned idle_cycles;

  int unsigned tx_wait;
  bit          tx_started;
  int unsigned rx_wait;
  bit          rx_calm;

  utf16_to_utf8_transcoder_core u_top (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pack one code point as UTF-8, lead byte in the low byte lane.
  function automatic char_item_t encode_char(logic [20:0] cp, bit last);
    char_item_t c;
    logic [7:0] b0, b1, b2, b3;
    b1 = '0;
    b2 = '0;
    b3 = '0;
    c  = '0;
    if (cp < 21'h80) begin
      b0 = {1'b0, cp[6:0]};
      c.byte_count = 3'd1;
    end else if (cp < 21'h800) begin
      b0 = {3'b110, cp[10:6]};
      b1 = {2'b10, cp[5:0]};
      c.byte_count = 3'd2;
    end else if (cp < 21'h10000) begin
      b0 = {4'b1110, cp[15:12]};
      b1 = {2'b10, cp[11:6]};
      b2 = {2'b10, cp[5:0]};
      c.byte_count = 3'd3;
    end else begin
      b0 = {5'b11110, cp[20:18]};
      b1 = {2'b10, cp[17:12]};
      b2 = {2'b10, cp[11:6]};
      b3 = {2'b10, cp[5:0]};
      c.byte_count = 3'd4;
    end
    c.utf8_bytes = {b3, b2, b1, b0};
    c.run_last   = last;
    return c;
  endfunction

  // Work out the characters one accepted unit causes and queue them.
  task automatic predict_chars(unit_item_t u);
    logic [20:0] cp;
    char_item_t  stale;
    bit          is_hi;
    bit          is_lo;
    is_hi = (u.code_unit >= HI_FIRST) && (u.code_unit <= HI_LAST);
    is_lo = (u.code_unit >= LO_FIRST) && (u.code_unit <= LO_LAST);
    if (hi_held) begin
      hi_held = 1'b0;
      if (is_lo) begin
        // Complete the pair: one supplementary character, nothing left held.
        cp = SUPP_BASE + {1'b0, hi_offset, u.code_unit[9:0]};
        expected_chars.push_back(encode_char(cp, 1'b1));
        pairs_made++;
        return;
      end
      // Flush the orphan high surrogate on its own.
      stale = encode_char({5'b0, HI_FIRST[15:10], hi_offset}, 1'b0);
      lone_surrogates++;
      if (is_hi && !u.final_unit) begin
        // The new high surrogate takes its place; the orphan ends the run.
        stale.run_last = 1'b1;
        expected_chars.push_back(stale);
        hi_offset = u.code_unit[9:0];
        hi_held   = 1'b1;
        return;
      end
      expected_chars.push_back(stale);
    end
    if (is_hi && !u.final_unit) begin
      // Hold it until the next unit decides what it is.
      hi_offset = u.code_unit[9:0];
      hi_held   = 1'b1;
      return;
    end
    if (is_hi || is_lo)
      lone_surrogates++;
    expected_chars.push_back(encode_char({5'b0, u.code_unit}, 1'b1));
  endtask

  function automatic void add_unit(logic [15:0] code, bit fin, bit calm);
    unit_plan_t p;
    p.item.code_unit  = code;
    p.item.final_unit = fin;
    p.gap             = calm ? 0 : $urandom_range(0, 7);
    p.drain_first     = 1'b0;
    pending_units.push_back(p);
  endfunction

  // Sender: offer the head of the plan after its gap, hold the payload
  // steady while stalled, and predict at the edge where an item is taken.
  always @(posedge clk) begin : unit_driver
    logic       next_valid;
    unit_item_t next_item;
    unit_plan_t plan;
    next_valid = unit_valid;
    next_item  = unit_item;
    if (rst) begin
      next_valid = 1'b0;
      tx_wait    = 0;
      tx_started = 1'b0;
    end else begin
      if (unit_valid && unit_stall)
        stall_cycles++;
      if (unit_valid && !unit_stall) begin
        predict_chars(unit_item);
        units_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_units.size() != 0) begin
        // Load the gap of a new head item once.
        if (!tx_started) begin
          tx_wait    = pending_units[0].gap;
          tx_started = 1'b1;
        end
        if (tx_wait != 0) begin
          tx_wait--;
        end else if (!pending_units[0].drain_first || expected_chars.size() == 0) begin
          plan       = pending_units.pop_front();
          next_item  = plan.item;
          next_valid = 1'b1;
          tx_started = 1'b0;
        end
      end
    end
    // One assignment per edge, so a back-to-back valid never dips.
    unit_valid <= next_valid;
    unit_item  <= next_item;
  end

  // Receiver: check each character taken against the oldest expectation,
  // then draw how long to stall before the next one.
  always @(posedge clk) begin : char_monitor
    char_item_t want;
    if (rst) begin
      char_stall <= 1'b0;
      rx_wait = 0;
      rx_calm = 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          char_errors++;
          if (char_errors <= 10)
            $display("char %0d unexpected: bytes %h count %0d last %b", chars_checked,
                     char_item.utf8_bytes, char_item.byte_count, char_item.run_last);
        end else begin
          want = expected_chars.pop_front();
          if (char_item.utf8_bytes !== want.utf8_bytes ||
              char_item.byte_count !== want.byte_count ||
              char_item.run_last !== want.run_last) begin
            char_errors++;
            if (char_errors <= 10)
              $display("char %0d mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       chars_checked, want.utf8_bytes, want.byte_count, want.run_last,
                       char_item.utf8_bytes, char_item.byte_count, char_item.run_last);
          end
        end
        // Switch between stalling and calm stretches now and then.
        if (chars_checked % 60 == 0)
          rx_calm = ($urandom_range(0, 2) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
        // Hold off once for a long stretch so the block backs up its input.
        if (chars_checked == LONG_HOLD_AT)
          rx_wait = LONG_HOLD_CYCLES;
      end
      char_stall <= (rx_wait != 0);
      if (rx_wait != 0)
        rx_wait--;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (unit_valid && !unit_stall) || (char_valid && !char_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("utf16_to_utf8_transcoder_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned planned;
    bit          calm;
    bit          last;
    logic [15:0] code;

    // Directed: encoding boundaries around each byte count.
    add_unit(16'h0000, 1'b0, 1'b0);
    add_unit(16'h007F, 1'b0, 1'b0);
    add_unit(16'h0080, 1'b0, 1'b0);
    add_unit(16'h07FF, 1'b0, 1'b0);
    add_unit(16'h0800, 1'b0, 1'b0);
    add_unit(16'hD7FF, 1'b0, 1'b0);
    add_unit(16'hE000, 1'b0, 1'b0);
    add_unit(16'hFFFF, 1'b1, 1'b0);
    // Lowest pair, then the highest pair with the final flag on the low half.
    add_unit(16'hD800, 1'b0, 1'b0);
    add_unit(16'hDC00, 1'b0, 1'b0);
    add_unit(16'hDBFF, 1'b0, 1'b1);
    add_unit(16'hDFFF, 1'b1, 1'b1);
    // Lone low surrogates, plain and final.
    add_unit(16'hDC00, 1'b0, 1'b0);
    add_unit(16'hDFFF, 1'b1, 1'b0);
    // Held high surrogate broken by an ordinary unit: two characters.
    add_unit(16'hD800, 1'b0, 1'b1);
    add_unit(16'h0041, 1'b0, 1'b1);
    // Held high surrogate replaced by another, which then pairs.
    add_unit(16'hDBFF, 1'b0, 1'b0);
    add_unit(16'hD800, 1'b0, 1'b0);
    add_unit(16'hDC00, 1'b0, 1'b0);
    // Held high surrogate followed by a final high surrogate: both alone.
    add_unit(16'hD801, 1'b0, 1'b1);
    add_unit(16'hDA00, 1'b1, 1'b1);
    // Final high surrogate with nothing held.
    add_unit(16'hDBFF, 1'b1, 1'b0);
    // Held high surrogate followed by a final BMP unit.
    add_unit(16'hD900, 1'b0, 1'b0);
    add_unit(16'hFFFF, 1'b1, 1'b0);

    // Random: mostly well-formed strings, some raw noise.
    while (pending_units.size() < UNIT_TOTAL) begin
      len  = $urandom_range(1, 12);
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1) == 0)
            code = 16'($urandom_range(16'hD800, 16'hDFFF));
          else
            code = 16'($urandom_range(0, 16'hFFFF));
          add_unit(code, 1'($urandom_range(0, 1)), calm);
        end
      end else begin
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1);
          case ($urandom_range(0, 3))
            0: add_unit(16'($urandom_range(0, 16'h007F)), last, calm);
            1: add_unit(16'($urandom_range(16'h0080, 16'h07FF)), last, calm);
            2: begin
              if ($urandom_range(0, 1) == 0)
                add_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last, calm);
              else
                add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last, calm);
            end
            default: begin
              add_unit(16'($urandom_range(HI_FIRST, HI_LAST)), 1'b0, calm);
              add_unit(16'($urandom_range(LO_FIRST, LO_LAST)), last, calm);
            end
          endcase
        end
      end
    end
    // Pause the sender once until the block has drained.
    pending_units[DRAIN_AT].drain_first = 1'b1;
    planned = pending_units.size();

    hi_held   = 1'b0;
    hi_offset = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every planned item to be taken, then for every expected char.
    do @(posedge clk); while (units_sent != planned);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0) begin
      $display("%0d expected chars never arrived", expected_chars.size());
      char_errors += expected_chars.size();
    end
    $display("Sent %0d code units, checked %0d UTF-8 chars (%0d pairs, %0d lone surrogates).",
             units_sent, chars_checked, pairs_made, lone_surrogates);
    $display("Input was stalled for %0d cycles; %0d mismatches.", stall_cycles, char_errors);
    if (char_errors == 0)
      $display("utf16_to_utf8_transcoder_core_tb OK");
    else
      $display("utf16_to_utf8_transcoder_core_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/utt_pkg.sv
design/utt_front.sv
design/utt_queue.sv
design/utt_back.sv
design/utf16_to_utf8_transcoder_core.sv
tb/utf16_to_utf8_transcoder_core_tb.sv
